### sv/point_pair_bearing_angle_assert.svh
// assertion macros for the point pair bearing block
`ifndef POINT_PAIR_BEARING_ANGLE_ASSERT_SVH
`define POINT_PAIR_BEARING_ANGLE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PPBA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PPBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/ppba_pkg.sv
// shared types, constants and arctangent table for the bearing pipeline
package ppba_pkg;

    localparam int COORD_WIDTH_DEF   = 16;
    localparam int FRACTION_BITS_DEF = 8;
    localparam int CORDIC_STEPS_DEF  = 18;

    localparam int MAX_STEPS = 32;
    localparam int GUARD_TOP = 57;   // guard shift is this minus the coordinate width
    localparam int ANG_BITS  = 24;   // angle kept in 2^-24 degree units
    localparam int ZW        = 34;   // signed rotation angle accumulator
    localparam int BW        = 34;   // unsigned bearing
    localparam int WHOLE_W   = 10;
    localparam int STATUS_W  = 2;

    typedef logic signed [ZW-1:0] t_zang;
    typedef logic        [BW-1:0] t_bear;

    localparam t_zang Z_90  = 34'sd1509949440;
    localparam t_zang Z_180 = 34'sd3019898880;

    localparam t_bear B_90    = 34'd1509949440;
    localparam t_bear B_180   = 34'd3019898880;
    localparam t_bear B_270   = 34'd4529848320;
    localparam t_bear B_360   = 34'd6039797760;
    localparam t_bear B_360M1 = 34'd6039797759;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_UNSET = 2'd1,
        ST_SAME  = 2'd2
    } t_status;

    // bearings that need no rotation
    typedef enum logic [1:0] {
        FX_UP    = 2'd0,
        FX_RIGHT = 2'd1,
        FX_DOWN  = 2'd2,
        FX_LEFT  = 2'd3
    } t_fixed;

    typedef struct packed {
        t_status status;
        logic    fixed;
        t_fixed  fsel;
        logic    dx_neg;
    } t_tag;

    // atan(2^-i) in 2^-24 degree units
    localparam logic [31:0] ATAN_TAB [MAX_STEPS] = '{
        32'd754974720, 32'd445687602, 32'd235489089, 32'd119537938,
        32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
        32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
        32'd234684,    32'd117342,    32'd58671,     32'd29335,
        32'd14668,     32'd7334,      32'd3667,      32'd1833,
        32'd917,       32'd458,       32'd229,       32'd115,
        32'd57,        32'd29,        32'd14,        32'd7,
        32'd4,         32'd2,         32'd1,         32'd0
    };

    function automatic t_zang atan_step(input logic [4:0] idx);
        return t_zang'({1'b0, ATAN_TAB[idx]});
    endfunction

endpackage

### sv/ppba_front.sv
// input stage: differences, special cases and pre-rotation into the right half plane
module ppba_front #(
    parameter int COORD_WIDTH = ppba_pkg::COORD_WIDTH_DEF,
    parameter int DW          = 61
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_end_y,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [DW-1:0]          o_x,
    output logic signed [DW-1:0]          o_y,
    output ppba_pkg::t_zang               o_z,
    output ppba_pkg::t_tag                o_tag
);
    import ppba_pkg::*;

    localparam int GUARD = DW - COORD_WIDTH - 4;

    logic signed [COORD_WIDTH:0] dx, dy, ax, xs0, ys0;
    logic                        unset, same, dy_pos;
    logic                        r_valid;
    logic signed [DW-1:0]        r_x, r_y, n_x, n_y;
    t_zang                       r_z, n_z;
    t_tag                        r_tag, n_tag;

    always_comb begin
        dx     = {i_end_x[COORD_WIDTH-1], i_end_x} - {i_start_x[COORD_WIDTH-1], i_start_x};
        dy     = {i_end_y[COORD_WIDTH-1], i_end_y} - {i_start_y[COORD_WIDTH-1], i_start_y};
        unset  = ((&i_start_x) && (&i_start_y)) || ((&i_end_x) && (&i_end_y));
        same   = (i_start_x == i_end_x) && (i_start_y == i_end_y);
        ax     = dx[COORD_WIDTH] ? -dx : dx;
        dy_pos = !dy[COORD_WIDTH] && (dy != '0);
        // pointing downward: rotate by 90 so x starts non-negative
        xs0    = dy_pos ? ax : -dy;
        ys0    = dy_pos ? dy : ax;
        n_x    = DW'(xs0) <<< GUARD;
        n_y    = DW'(ys0) <<< GUARD;
        n_z    = dy_pos ? Z_90 : '0;

        n_tag.status = unset ? ST_UNSET : (same ? ST_SAME : ST_OK);
        n_tag.fixed  = unset || same || (dx == '0) || (dy == '0);
        if (dx == '0) begin
            n_tag.fsel = dy[COORD_WIDTH] ? FX_UP : FX_DOWN;
        end else begin
            n_tag.fsel = dx[COORD_WIDTH] ? FX_LEFT : FX_RIGHT;
        end
        n_tag.dx_neg = dx[COORD_WIDTH];
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
            r_tag <= n_tag;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_tag   = r_tag;

endmodule

### sv/ppba_cell.sv
// one vectoring rotation step, registered, with its own transfer handshake
module ppba_cell #(
    parameter int DW   = 61,
    parameter int STEP = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [DW-1:0] i_x,
    input  logic signed [DW-1:0] i_y,
    input  ppba_pkg::t_zang      i_z,
    input  ppba_pkg::t_tag       i_tag,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [DW-1:0] o_x,
    output logic signed [DW-1:0] o_y,
    output ppba_pkg::t_zang      o_z,
    output ppba_pkg::t_tag       o_tag
);
    import ppba_pkg::*;

    localparam t_zang ATAN = atan_step(5'(STEP));

    logic signed [DW-1:0] xs, ys, n_x, n_y, r_x, r_y;
    t_zang                n_z, r_z;
    t_tag                 r_tag;
    logic                 r_valid;

    always_comb begin
        xs = i_x >>> STEP;
        ys = i_y >>> STEP;
        // drive y towards zero
        if (i_y[DW-1]) begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - ATAN;
        end else begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + ATAN;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
            r_tag <= i_tag;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_tag   = r_tag;

endmodule

### sv/ppba_back.sv
// output stage: clamp, fold into the compass range, truncate and hold the result
module ppba_back #(
    parameter int FRACTION_BITS = ppba_pkg::FRACTION_BITS_DEF,
    parameter int FW            = (FRACTION_BITS > 0) ? FRACTION_BITS : 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  ppba_pkg::t_zang                     i_z,
    input  ppba_pkg::t_tag                      i_tag,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [ppba_pkg::STATUS_W-1:0]       o_status,
    output logic signed [ppba_pkg::WHOLE_W-1:0] o_whole,
    output logic [FW-1:0]                       o_frac
);
    import ppba_pkg::*;

    t_bear                      a, bearing;
    logic [STATUS_W-1:0]        n_status, r_status;
    logic signed [WHOLE_W-1:0]  n_whole, r_whole;
    logic [FW-1:0]              n_frac, r_frac;
    logic                       r_valid;

    always_comb begin
        if (i_z < 0) begin
            a = '0;
        end else if (i_z > Z_180) begin
            a = B_180;
        end else begin
            a = t_bear'(i_z);
        end

        if (i_tag.fixed) begin
            unique case (i_tag.fsel)
                FX_UP:    bearing = '0;
                FX_RIGHT: bearing = B_90;
                FX_DOWN:  bearing = B_180;
                FX_LEFT:  bearing = B_270;
                default:  bearing = '0;
            endcase
        end else if (i_tag.dx_neg) begin
            // a full turn is not a valid code, keep just below it
            bearing = (a == '0) ? B_360M1 : B_360 - a;
        end else begin
            bearing = a;
        end

        n_status = i_tag.status;
        if (i_tag.status != ST_OK) begin
            n_whole = '1;
            n_frac  = '0;
        end else begin
            n_whole = bearing[ANG_BITS +: WHOLE_W];
            n_frac  = (FRACTION_BITS == 0) ? '0 : bearing[ANG_BITS-1 -: FW];
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_status <= n_status;
            r_whole  <= n_whole;
            r_frac   <= n_frac;
        end
    end

    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_whole  = r_whole;
    assign o_frac   = r_frac;

endmodule

### sv/point_pair_bearing_angle.sv
// top level: compass bearing between two screen points through a chain of rotation cells
//
//   channel | direction | handshake                    | payload
//   --------+-----------+------------------------------+-----------------------------------
//   in      | input     | i_in_valid / o_in_ready      | i_start_x i_start_y i_end_x i_end_y
//   out     | output    | o_out_valid / i_out_ready    | o_status o_angle_whole
//           |           |                              | o_angle_fraction
//
// stages in order: input stage, one cell per rotation step, output stage
// one pair is taken every cycle while the output side keeps up
// each stage holds its own valid bit, so bubbles close up while the output is stalled
// a stage takes a transfer when it is empty or its successor is taking its item
// synchronous active-low reset clears the valid bits only; no clearing pass
module point_pair_bearing_angle #(
    parameter int COORD_WIDTH   = ppba_pkg::COORD_WIDTH_DEF,
    parameter int FRACTION_BITS = ppba_pkg::FRACTION_BITS_DEF,
    parameter int CORDIC_STEPS  = ppba_pkg::CORDIC_STEPS_DEF,
    parameter int FW            = (FRACTION_BITS > 0) ? FRACTION_BITS : 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [COORD_WIDTH-1:0]       i_start_x,
    input  logic signed [COORD_WIDTH-1:0]       i_start_y,
    input  logic signed [COORD_WIDTH-1:0]       i_end_x,
    input  logic signed [COORD_WIDTH-1:0]       i_end_y,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [ppba_pkg::STATUS_W-1:0]       o_status,
    output logic signed [ppba_pkg::WHOLE_W-1:0] o_angle_whole,
    output logic [FW-1:0]                       o_angle_fraction
);
    import ppba_pkg::*;

    localparam int GUARD = GUARD_TOP - COORD_WIDTH;
    localparam int DW    = COORD_WIDTH + GUARD + 4;

    logic                 w_valid [CORDIC_STEPS+1];
    logic                 w_ready [CORDIC_STEPS+1];
    logic signed [DW-1:0] w_x     [CORDIC_STEPS+1];
    logic signed [DW-1:0] w_y     [CORDIC_STEPS+1];
    t_zang                w_z     [CORDIC_STEPS+1];
    t_tag                 w_tag   [CORDIC_STEPS+1];

    ppba_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .DW          (DW)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_start_x (i_start_x),
        .i_start_y (i_start_y),
        .i_end_x   (i_end_x),
        .i_end_y   (i_end_y),
        .o_valid   (w_valid[0]),
        .i_ready   (w_ready[0]),
        .o_x       (w_x[0]),
        .o_y       (w_y[0]),
        .o_z       (w_z[0]),
        .o_tag     (w_tag[0])
    );

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
        ppba_cell #(
            .DW   (DW),
            .STEP (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_x     (w_x[k]),
            .i_y     (w_y[k]),
            .i_z     (w_z[k]),
            .i_tag   (w_tag[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_x     (w_x[k+1]),
            .o_y     (w_y[k+1]),
            .o_z     (w_z[k+1]),
            .o_tag   (w_tag[k+1])
        );
    end

    ppba_back #(
        .FRACTION_BITS (FRACTION_BITS),
        .FW            (FW)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_valid[CORDIC_STEPS]),
        .o_ready  (w_ready[CORDIC_STEPS]),
        .i_z      (w_z[CORDIC_STEPS]),
        .i_tag    (w_tag[CORDIC_STEPS]),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_status (o_status),
        .o_whole  (o_angle_whole),
        .o_frac   (o_angle_fraction)
    );

    `include "point_pair_bearing_angle_assert.svh"

    // an error result never carries an angle
    `PPBA_ASSERT_IMPL(a_err_no_angle, o_out_valid && (o_status != ST_OK), (o_angle_whole == '1) && (o_angle_fraction == '0), "error result carries an angle")
    // a good result stays inside one turn
    `PPBA_ASSERT_IMPL(a_whole_range, o_out_valid && (o_status == ST_OK), (o_angle_whole >= 0) && (o_angle_whole < 360), "whole degrees out of range")
    // an empty output stage means every stage can move, so the input must be open
    `PPBA_ASSERT_IMPL(a_ready_chain, !o_out_valid, o_in_ready, "input closed while output empty")
    // no unused status code reaches the output
    `PPBA_ASSERT_IMPL(a_status_code, o_out_valid, (o_status == ST_OK) || (o_status == ST_UNSET) || (o_status == ST_SAME), "unknown status code")

endmodule

### tb/tb_point_pair_bearing_angle.sv
// self-checking testbench for the point pair bearing block: directed table, then random pairs
module tb_point_pair_bearing_angle;
    import ppba_pkg::*;

    localparam int COORD_W = COORD_WIDTH_DEF;
    localparam int FRAC_W  = FRACTION_BITS_DEF;
    localparam int STEPS   = CORDIC_STEPS_DEF;
    localparam int GUARD   = GUARD_TOP - COORD_W;
    localparam int LATENCY = STEPS + 2;
    localparam int N_RANDOM = 750;
    localparam int N_CALM   = 150;   // closing stretch with no idling on either side

    localparam longint DEG = 64'sd1 << ANG_BITS;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_status                     status;
        logic signed [WHOLE_W-1:0]   whole;
        logic        [FRAC_W-1:0]    frac;
    } t_bearing_res;

    typedef struct packed {
        int      sx;
        int      sy;
        int      ex;
        int      ey;
        bit      typed;
        t_status st;
        int      whole;
        int      frac;
    } t_row;

    // arctangent of 2^-i in 2^-24 degree units
    localparam longint ATAN_DEG [32] = '{
        754974720, 445687602, 235489089, 119537938,
        60000934,  30029717,  15018523,  7509720,
        3754917,   1877466,   938734,    469367,
        234684,    117342,    58671,     29335,
        14668,     7334,      3667,      1833,
        917,       458,       229,       115,
        57,        29,        14,        7,
        4,         2,         1,         0
    };

    localparam int N_DIRECTED = 25;
    localparam t_row DIRECTED_PAIRS [N_DIRECTED] = '{
        '{-1, -1, 10, 10, 1'b1, ST_UNSET, -1, 0},
        '{5, 5, -1, -1, 1'b1, ST_UNSET, -1, 0},
        '{-1, -1, -1, -1, 1'b1, ST_UNSET, -1, 0},          // unset wins over coincident
        '{100, -200, 100, -200, 1'b1, ST_SAME, -1, 0},
        '{-32768, 32767, -32768, 32767, 1'b1, ST_SAME, -1, 0},
        '{0, 0, 0, -5, 1'b1, ST_OK, 0, 0},
        '{0, 0, 0, 5, 1'b1, ST_OK, 180, 0},
        '{0, 0, 7, 0, 1'b1, ST_OK, 90, 0},
        '{0, 0, -7, 0, 1'b1, ST_OK, 270, 0},
        '{0, 32767, 0, -32768, 1'b1, ST_OK, 0, 0},
        '{-32768, -32768, -32768, 32767, 1'b1, ST_OK, 180, 0},
        '{-32768, 0, 32767, 0, 1'b1, ST_OK, 90, 0},
        '{32767, 5, -32768, 5, 1'b1, ST_OK, 270, 0},
        '{-1, 7, -1, -2, 1'b1, ST_OK, 0, 0},              // x of unset marker only
        '{-32768, -32768, 32767, 32767, 1'b0, ST_OK, 0, 0},
        '{32767, 32767, -32768, -32768, 1'b0, ST_OK, 0, 0},
        '{-32768, 32767, 32767, -32768, 1'b0, ST_OK, 0, 0},
        '{32767, -32768, -32768, 32767, 1'b0, ST_OK, 0, 0},
        '{0, 32767, -1, -32768, 1'b0, ST_OK, 0, 0},       // just left of up, clamp below 360
        '{0, 32767, 1, -32768, 1'b0, ST_OK, 0, 0},
        '{0, -32768, 1, 32767, 1'b0, ST_OK, 0, 0},
        '{0, -32768, -1, 32767, 1'b0, ST_OK, 0, 0},
        '{-32768, 0, 32767, 1, 1'b0, ST_OK, 0, 0},
        '{32767, 0, -32768, -1, 1'b0, ST_OK, 0, 0},
        '{-1, 0, 0, -1, 1'b0, ST_OK, 0, 0}
    };

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_ready;
    t_coord                     i_start_x;
    t_coord                     i_start_y;
    t_coord                     i_end_x;
    t_coord                     i_end_y;
    logic                       o_out_valid;
    logic                       i_out_ready;
    logic [STATUS_W-1:0]        o_status;
    logic signed [WHOLE_W-1:0]  o_angle_whole;
    logic [FRAC_W-1:0]          o_angle_fraction;

    t_bearing_res pending_bearings [$];
    int           n_fail;
    bit           idle_on;

    point_pair_bearing_angle #(
        .COORD_WIDTH   (COORD_W),
        .FRACTION_BITS (FRAC_W),
        .CORDIC_STEPS  (STEPS)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_start_x        (i_start_x),
        .i_start_y        (i_start_y),
        .i_end_x          (i_end_x),
        .i_end_y          (i_end_y),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_angle_whole    (o_angle_whole),
        .o_angle_fraction (o_angle_fraction)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic t_bearing_res bearing_of_pair(input t_coord sx, input t_coord sy,
                                                     input t_coord ex, input t_coord ey);
        t_bearing_res r;
        longint dx, dy, x, y, z, xs, ys, t, bear;
        int     i;
        r.status = ST_OK;
        r.whole  = '1;
        r.frac   = '0;
        if ((sx == -1 && sy == -1) || (ex == -1 && ey == -1)) begin
            r.status = ST_UNSET;
            return r;
        end
        if (sx == ex && sy == ey) begin
            r.status = ST_SAME;
            return r;
        end
        dx = longint'(ex) - longint'(sx);
        dy = longint'(ey) - longint'(sy);
        if (dx == 0) begin
            bear = (dy < 0) ? 0 : 180 * DEG;
        end else if (dy == 0) begin
            bear = (dx < 0) ? 270 * DEG : 90 * DEG;
        end else begin
            // rotate (-dy, |dx|) onto the x axis, angle gathered in z
            x = (-dy) <<< GUARD;
            y = ((dx < 0) ? -dx : dx) <<< GUARD;
            z = 0;
            if (x < 0) begin
                t = x;
                x = y;
                y = -t;
                z = 90 * DEG;
            end
            for (i = 0; i < STEPS && i < 32; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y < 0) begin
                    x -= ys;
                    y += xs;
                    z -= ATAN_DEG[i];
                end else begin
                    x += ys;
                    y -= xs;
                    z += ATAN_DEG[i];
                end
            end
            if (z < 0)
                z = 0;
            if (z > 180 * DEG)
                z = 180 * DEG;
            if (dx < 0) begin
                bear = 360 * DEG - z;
                if (bear >= 360 * DEG)
                    bear = 360 * DEG - 1;
            end else begin
                bear = z;
            end
        end
        r.whole = WHOLE_W'(bear >>> ANG_BITS);
        r.frac  = FRAC_W'(bear >>> (ANG_BITS - FRAC_W));
        return r;
    endfunction

    // present one pair, hold it until the transfer, then maybe drop valid for a while
    task automatic send_pair(input t_coord sx, input t_coord sy, input t_coord ex,
                             input t_coord ey, input t_bearing_res want);
        i_in_valid <= 1'b1;
        i_start_x  <= sx;
        i_start_y  <= sy;
        i_end_x    <= ex;
        i_end_y    <= ey;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        pending_bearings.push_back(want);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    task automatic send_random_pair();
        t_coord sx, sy, ex, ey;
        int     kind;
        kind = $urandom_range(0, 99);
        sx = t_coord'($urandom);
        sy = t_coord'($urandom);
        ex = t_coord'($urandom);
        ey = t_coord'($urandom);
        if (kind >= 60 && kind < 75) begin
            ex = sx + t_coord'($urandom_range(0, 16)) - t_coord'(8);
            ey = sy + t_coord'($urandom_range(0, 16)) - t_coord'(8);
        end else if (kind >= 75 && kind < 83) begin
            if ($urandom_range(0, 1))
                ex = sx;
            else
                ey = sy;
        end else if (kind >= 83 && kind < 89) begin
            case ($urandom_range(0, 2))
                0: begin
                    sx = -1;
                    sy = -1;
                end
                1: begin
                    ex = -1;
                    ey = -1;
                end
                default: begin
                    sx = -1;
                    sy = -1;
                    ex = -1;
                    ey = -1;
                end
            endcase
        end else if (kind >= 89 && kind < 94) begin
            ex = sx;
            ey = sy;
        end else if (kind >= 94) begin
            // close to an axis: one small offset against a long run
            if ($urandom_range(0, 1))
                ex = sx + t_coord'($urandom_range(0, 6)) - t_coord'(3);
            else
                ey = sy + t_coord'($urandom_range(0, 6)) - t_coord'(3);
        end
        send_pair(sx, sy, ex, ey, bearing_of_pair(sx, sy, ex, ey));
    endtask

    // output side: ready in random runs, broken by stalls of random length while idling is on
    initial begin
        forever begin
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            if (idle_on) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_bearing_res want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_bearings.size() == 0) begin
                n_fail++;
                $display("%0t: result with none expected, status %0d angle %0d frac %0d",
                         $time, o_status, o_angle_whole, o_angle_fraction);
            end else begin
                want = pending_bearings.pop_front();
                if (o_status !== want.status) begin
                    n_fail++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                end
                if (o_angle_whole !== want.whole) begin
                    n_fail++;
                    $display("%0t: angle_whole expected %0d actual %0d",
                             $time, want.whole, o_angle_whole);
                end
                if (o_angle_fraction !== want.frac) begin
                    n_fail++;
                    $display("%0t: angle_fraction expected %0d actual %0d",
                             $time, want.frac, o_angle_fraction);
                end
            end
        end
    end

    initial begin : stimulus
        t_row         row;
        t_bearing_res want;
        int           n;
        n_fail     = 0;
        idle_on    = 1'b1;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_start_x  <= '0;
        i_start_y  <= '0;
        i_end_x    <= '0;
        i_end_y    <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (n = 0; n < N_DIRECTED; n++) begin
            row = DIRECTED_PAIRS[n];
            if (row.typed) begin
                want.status = row.st;
                want.whole  = WHOLE_W'(row.whole);
                want.frac   = FRAC_W'(row.frac);
            end else begin
                want = bearing_of_pair(t_coord'(row.sx), t_coord'(row.sy),
                                       t_coord'(row.ex), t_coord'(row.ey));
            end
            send_pair(t_coord'(row.sx), t_coord'(row.sy), t_coord'(row.ex),
                      t_coord'(row.ey), want);
        end

        for (n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - N_CALM)
                idle_on = 1'b0;
            send_random_pair();
        end
        i_in_valid <= 1'b0;

        while (pending_bearings.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);

        if (n_fail == 0)
            $display("point_pair_bearing_angle verification clean");
        else
            $display("point_pair_bearing_angle verification failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("point_pair_bearing_angle verification failed");
        $finish;
    end

endmodule

### point_pair_bearing_angle.f
+incdir+sv
sv/ppba_pkg.sv
sv/ppba_front.sv
sv/ppba_cell.sv
sv/ppba_back.sv
sv/point_pair_bearing_angle.sv
tb/tb_point_pair_bearing_angle.sv
